// File: hdl/lkey_pkg.sv
// Shared types, SHA-256 constants and round functions for the Lamport key slot generator.
`timescale 1ns / 1ps
package lkey_pkg;

  localparam int MessageBits = 256;
  localparam int SlotCount   = 2 * MessageBits;
  localparam int SlotW       = 9;
  localparam int SeedWordW   = 64;
  localparam int CfgIdxW     = 3;
  localparam int Rounds      = 64;

  localparam logic [CfgIdxW-1:0] RegSeed0 = 3'd0;
  localparam logic [CfgIdxW-1:0] RegSeed1 = 3'd1;
  localparam logic [CfgIdxW-1:0] RegSeed2 = 3'd2;
  localparam logic [CfgIdxW-1:0] RegSeed3 = 3'd3;

  typedef logic [31:0] word_t;
  typedef word_t [7:0]  hstate_t;   // [0] is a / H0
  typedef word_t [15:0] block_t;    // [0] is the word used next

  typedef struct packed {
    logic    in_range;
    hstate_t secret;
  } side_t;

  localparam word_t PadWord    = 32'h8000_0000;
  localparam word_t SecretBits = 32'd288;
  localparam word_t PublicBits = 32'd256;

  localparam word_t RoundK [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam word_t InitH [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  function automatic word_t bsig0(input word_t x);
    return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
  endfunction

  function automatic word_t bsig1(input word_t x);
    return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
  endfunction

  function automatic word_t ssig0(input word_t x);
    return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ (x >> 3);
  endfunction

  function automatic word_t ssig1(input word_t x);
    return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ (x >> 10);
  endfunction

endpackage

// File: hdl/lkey_round.sv
// One registered SHA-256 round with its message schedule step.
`timescale 1ns / 1ps
module lkey_round (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   en_i,
  input  logic                   valid_i,
  input  lkey_pkg::hstate_t      state_i,
  input  lkey_pkg::block_t       win_i,
  input  lkey_pkg::side_t        side_i,
  input  lkey_pkg::word_t        k_i,
  output logic                   valid_o,
  output lkey_pkg::hstate_t      state_o,
  output lkey_pkg::block_t       win_o,
  output lkey_pkg::side_t        side_o
);

  logic              valid_q;
  lkey_pkg::hstate_t state_d, state_q;
  lkey_pkg::block_t  win_d, win_q;
  lkey_pkg::side_t   side_q;
  lkey_pkg::word_t   t1, t2, ch, maj;

  always_comb begin
    ch  = (state_i[4] & state_i[5]) ^ (~state_i[4] & state_i[6]);
    maj = (state_i[0] & state_i[1]) ^ (state_i[0] & state_i[2]) ^ (state_i[1] & state_i[2]);
    t1  = state_i[7] + lkey_pkg::bsig1(state_i[4]) + ch + k_i + win_i[0];
    t2  = lkey_pkg::bsig0(state_i[0]) + maj;
    state_d[0] = t1 + t2;
    state_d[1] = state_i[0];
    state_d[2] = state_i[1];
    state_d[3] = state_i[2];
    state_d[4] = state_i[3] + t1;
    state_d[5] = state_i[4];
    state_d[6] = state_i[5];
    state_d[7] = state_i[6];
    // advance the 16-word schedule window by one word
    for (int i = 0; i < 15; i++) begin
      win_d[i] = win_i[i+1];
    end
    win_d[15] = win_i[0] + lkey_pkg::ssig0(win_i[1]) + win_i[9] + lkey_pkg::ssig1(win_i[14]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      state_q <= state_d;
      win_q   <= win_d;
      side_q  <= side_i;
    end
  end

  assign valid_o = valid_q;
  assign state_o = state_q;
  assign win_o   = win_q;
  assign side_o  = side_q;

endmodule

// File: hdl/lkey_compress.sv
// Fully unrolled single-block SHA-256 compression, one round per stage.
`timescale 1ns / 1ps
module lkey_compress (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   en_i,
  input  logic                   valid_i,
  input  lkey_pkg::block_t       block_i,
  input  lkey_pkg::side_t        side_i,
  output logic                   valid_o,
  output lkey_pkg::hstate_t      digest_o,
  output lkey_pkg::side_t        side_o
);

  logic              valid_s [lkey_pkg::Rounds+1];
  lkey_pkg::hstate_t state_s [lkey_pkg::Rounds+1];
  lkey_pkg::block_t  win_s   [lkey_pkg::Rounds+1];
  lkey_pkg::side_t   side_s  [lkey_pkg::Rounds+1];

  logic              valid_q;
  lkey_pkg::hstate_t digest_d, digest_q;
  lkey_pkg::side_t   side_q;

  for (genvar i = 0; i < 8; i++) begin : g_init
    assign state_s[0][i] = lkey_pkg::InitH[i];
  end

  assign valid_s[0] = valid_i;
  assign win_s[0]   = block_i;
  assign side_s[0]  = side_i;

  for (genvar r = 0; r < lkey_pkg::Rounds; r++) begin : g_round
    lkey_round u_round (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en_i),
      .valid_i (valid_s[r]),
      .state_i (state_s[r]),
      .win_i   (win_s[r]),
      .side_i  (side_s[r]),
      .k_i     (lkey_pkg::RoundK[r]),
      .valid_o (valid_s[r+1]),
      .state_o (state_s[r+1]),
      .win_o   (win_s[r+1]),
      .side_o  (side_s[r+1])
    );
  end

  // feed-forward of the initial hash value
  always_comb begin
    for (int i = 0; i < 8; i++) begin
      digest_d[i] = lkey_pkg::InitH[i] + state_s[lkey_pkg::Rounds][i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_s[lkey_pkg::Rounds];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      digest_q <= digest_d;
      side_q   <= side_s[lkey_pkg::Rounds];
    end
  end

  assign valid_o  = valid_q;
  assign digest_o = digest_q;
  assign side_o   = side_q;

endmodule

// File: hdl/lamport_key_slot_generator_unit.sv
// Top level: seed registers, two chained SHA-256 pipelines and the result register.
//
//   channel  | handshake            | payload
//   ---------+----------------------+--------------------------------------
//   in       | in_valid_i/ready_o   | slot_index_i (9 b)
//   out      | out_valid_o/ready_i  | secret_word0..3_o, public_word0..3_o
//   cfg      | cfg_we_i             | cfg_idx_i (3 b), cfg_data_i (64 b)
//
// One slot index enters per cycle while no result is stalled; registers sit at the block build,
// the 64 rounds plus feed-forward per digest, and the result register.
// Reset clears the seed and all valid bits; no clearing pass.
// A stalled result freezes the whole pipeline in place; nothing is dropped or repeated.
`timescale 1ns / 1ps
module lamport_key_slot_generator_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [63:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [8:0]  slot_index_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [63:0] secret_word0_o,
  output logic [63:0] secret_word1_o,
  output logic [63:0] secret_word2_o,
  output logic [63:0] secret_word3_o,
  output logic [63:0] public_word0_o,
  output logic [63:0] public_word1_o,
  output logic [63:0] public_word2_o,
  output logic [63:0] public_word3_o
);

  logic [lkey_pkg::SeedWordW-1:0] seed_q [4];

  logic              en;
  logic              v0_q;
  lkey_pkg::block_t  blk0_q, blk1;
  lkey_pkg::block_t  blk0_d;
  lkey_pkg::side_t   side0_q, side0_d, side1, side2_in, side2;
  logic              v1, v2;
  lkey_pkg::hstate_t dig1, dig2;

  logic              out_valid_q;
  lkey_pkg::hstate_t sec_q, pub_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 4; i++) begin
        seed_q[i] <= '0;
      end
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        lkey_pkg::RegSeed0: seed_q[0] <= cfg_data_i;
        lkey_pkg::RegSeed1: seed_q[1] <= cfg_data_i;
        lkey_pkg::RegSeed2: seed_q[2] <= cfg_data_i;
        lkey_pkg::RegSeed3: seed_q[3] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // the whole pipeline advances unless a result is waiting and not taken
  assign en         = !out_valid_q || out_ready_i;
  assign in_ready_o = en;

  always_comb begin
    blk0_d = '0;
    for (int i = 0; i < 4; i++) begin
      blk0_d[2*i]   = seed_q[i][63:32];
      blk0_d[2*i+1] = seed_q[i][31:0];
    end
    blk0_d[8]  = {23'd0, slot_index_i};
    blk0_d[9]  = lkey_pkg::PadWord;
    blk0_d[15] = lkey_pkg::SecretBits;
    side0_d.in_range = {1'b0, slot_index_i} < 10'(lkey_pkg::SlotCount);
    side0_d.secret   = '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
    end else if (en) begin
      v0_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      blk0_q  <= blk0_d;
      side0_q <= side0_d;
    end
  end

  lkey_compress u_secret (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .valid_i  (v0_q),
    .block_i  (blk0_q),
    .side_i   (side0_q),
    .valid_o  (v1),
    .digest_o (dig1),
    .side_o   (side1)
  );

  always_comb begin
    blk1 = '0;
    for (int i = 0; i < 8; i++) begin
      blk1[i] = dig1[i];
    end
    blk1[8]  = lkey_pkg::PadWord;
    blk1[15] = lkey_pkg::PublicBits;
    side2_in.in_range = side1.in_range;
    side2_in.secret   = dig1;
  end

  lkey_compress u_public (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .valid_i  (v1),
    .block_i  (blk1),
    .side_i   (side2_in),
    .valid_o  (v2),
    .digest_o (dig2),
    .side_o   (side2)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= v2;
    end
  end

  // drop both digests to zero for a slot beyond the key
  always_ff @(posedge clk_i) begin
    if (en) begin
      sec_q <= side2.in_range ? side2.secret : '0;
      pub_q <= side2.in_range ? dig2 : '0;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign secret_word0_o = {sec_q[0], sec_q[1]};
  assign secret_word1_o = {sec_q[2], sec_q[3]};
  assign secret_word2_o = {sec_q[4], sec_q[5]};
  assign secret_word3_o = {sec_q[6], sec_q[7]};
  assign public_word0_o = {pub_q[0], pub_q[1]};
  assign public_word1_o = {pub_q[2], pub_q[3]};
  assign public_word2_o = {pub_q[4], pub_q[5]};
  assign public_word3_o = {pub_q[6], pub_q[7]};

endmodule

// File: bench/lamport_key_slot_generator_unit_test.sv
// Self-checking bench for the Lamport key slot generator: predicted digests versus the block.
`timescale 1ns / 1ps
module lamport_key_slot_generator_unit_test;

  typedef struct packed {
    logic [3:0][63:0] secret;
    logic [3:0][63:0] pub;
  } slot_digest_t;

  // Predicts both digests per slot and holds them until the block returns them.
  class slot_scoreboard;
    logic [63:0] seed [4];
    slot_digest_t pending_digests [$];
    int errors;

    function new();
      foreach (seed[i]) seed[i] = '0;
      errors = 0;
    endfunction

    function void write_seed(logic [2:0] idx, logic [63:0] val);
      if (idx <= lkey_pkg::RegSeed3) seed[idx[1:0]] = val;
    endfunction

    static function lkey_pkg::word_t ror(lkey_pkg::word_t x, int n);
      return (x >> n) | (x << (32 - n));
    endfunction

    static function void sha_block(input lkey_pkg::word_t blk [16],
                                   output lkey_pkg::word_t dig [8]);
      lkey_pkg::word_t w [64];
      lkey_pkg::word_t v [8];
      lkey_pkg::word_t t1, t2, ch, mj;
      for (int t = 0; t < 16; t++) w[t] = blk[t];
      for (int t = 16; t < 64; t++)
        w[t] = w[t-16] + w[t-7]
             + (ror(w[t-15], 7) ^ ror(w[t-15], 18) ^ (w[t-15] >> 3))
             + (ror(w[t-2], 17) ^ ror(w[t-2], 19) ^ (w[t-2] >> 10));
      for (int t = 0; t < 8; t++) v[t] = lkey_pkg::InitH[t];
      for (int t = 0; t < 64; t++) begin
        ch = (v[4] & v[5]) ^ (~v[4] & v[6]);
        mj = (v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]);
        t1 = v[7] + (ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25)) + ch
           + lkey_pkg::RoundK[t] + w[t];
        t2 = (ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22)) + mj;
        for (int k = 7; k > 0; k--) v[k] = v[k-1];
        v[4] = v[4] + t1;
        v[0] = t1 + t2;
      end
      for (int t = 0; t < 8; t++) dig[t] = lkey_pkg::InitH[t] + v[t];
    endfunction

    function void note_slot(logic [8:0] slot);
      lkey_pkg::word_t blk [16];
      lkey_pkg::word_t sec [8];
      lkey_pkg::word_t pb [8];
      slot_digest_t d;
      foreach (blk[i]) blk[i] = '0;
      for (int i = 0; i < 4; i++) begin
        blk[2*i]   = seed[i][63:32];
        blk[2*i+1] = seed[i][31:0];
      end
      blk[8]  = {23'd0, slot};
      blk[9]  = lkey_pkg::PadWord;
      blk[15] = lkey_pkg::SecretBits;
      sha_block(blk, sec);
      foreach (blk[i]) blk[i] = '0;
      for (int i = 0; i < 8; i++) blk[i] = sec[i];
      blk[8]  = lkey_pkg::PadWord;
      blk[15] = lkey_pkg::PublicBits;
      sha_block(blk, pb);
      for (int i = 0; i < 4; i++) begin
        d.secret[i] = {sec[2*i], sec[2*i+1]};
        d.pub[i]    = {pb[2*i], pb[2*i+1]};
      end
      pending_digests.push_back(d);
    endfunction

    function void check_result(slot_digest_t got);
      slot_digest_t exp_d;
      if (pending_digests.size() == 0) begin
        $error("result beat with nothing pending");
        errors++;
        return;
      end
      exp_d = pending_digests.pop_front();
      for (int i = 0; i < 4; i++) begin
        if (got.secret[i] !== exp_d.secret[i]) begin
          $error("secret_word%0d expected %h actual %h", i, exp_d.secret[i], got.secret[i]);
          errors++;
        end
        if (got.pub[i] !== exp_d.pub[i]) begin
          $error("public_word%0d expected %h actual %h", i, exp_d.pub[i], got.pub[i]);
          errors++;
        end
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [2:0]  cfg_idx_i = '0;
  logic [63:0] cfg_data_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [8:0]  slot_index_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [63:0] secret_word0_o, secret_word1_o, secret_word2_o, secret_word3_o;
  logic [63:0] public_word0_o, public_word1_o, public_word2_o, public_word3_o;

  slot_scoreboard sb = new();
  int cycle_count = 0;
  bit long_hold_req = 1'b0;

  lamport_key_slot_generator_unit uut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 300000) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Receiver: check each result beat, stall on a changing pattern, one long hold-off.
  int rx_mode = 0;
  int rx_left = 0;
  int hold_left = 0;
  always @(posedge clk_i) begin
    slot_digest_t got;
    if (rst_ni && out_valid_o && out_ready_i) begin
      got.secret = {secret_word3_o, secret_word2_o, secret_word1_o, secret_word0_o};
      got.pub    = {public_word3_o, public_word2_o, public_word1_o, public_word0_o};
      sb.check_result(got);
    end
    if (long_hold_req && hold_left == 0) begin
      long_hold_req <= 1'b0;
      hold_left <= 600;
    end
    if (rx_left == 0) begin
      rx_mode <= int'($urandom_range(0, 3));
      rx_left <= int'($urandom_range(10, 80));
    end else begin
      rx_left <= rx_left - 1;
    end
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready_i <= 1'b0;
    end else begin
      case (rx_mode)
        0, 1: out_ready_i <= 1'b1;
        2: out_ready_i <= 1'($urandom_range(0, 1));
        default: out_ready_i <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  // Call at a rising edge; returns at the edge where the beat is taken.
  task automatic send_slot(logic [8:0] slot);
    in_valid_i <= 1'b1;
    slot_index_i <= slot;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    sb.note_slot(slot);
  endtask

  task automatic end_burst();
    int gap;
    in_valid_i <= 1'b0;
    gap = int'($urandom_range(1, 12));
    repeat (gap) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [63:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    sb.write_seed(idx, val);
    cfg_we_i <= 1'b0;
  endtask

  task automatic drain();
    while (sb.pending_digests.size() != 0) @(posedge clk_i);
    repeat (140) @(posedge clk_i);
  endtask

  task automatic random_slots(int count);
    int burst;
    int sent;
    sent = 0;
    while (sent < count) begin
      burst = ($urandom_range(0, 5) == 0) ? int'($urandom_range(30, 90))
                                          : int'($urandom_range(1, 16));
      for (int i = 0; i < burst && sent < count; i++) begin
        send_slot(9'($urandom_range(0, 511)));
        sent++;
      end
      if ($urandom_range(0, 3) != 0) end_burst();
    end
    in_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  initial begin
    logic [63:0] seeds [4];
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset seed, edge slots and a few walking bits.
    send_slot(9'd0);
    send_slot(9'd1);
    send_slot(9'd510);
    send_slot(9'd511);
    for (int b = 0; b < 9; b++) send_slot(9'd1 << b);
    end_burst();
    send_slot(9'h0AA);
    send_slot(9'h155);
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    drain();

    for (int ph = 0; ph < 5; ph++) begin
      for (int i = 0; i < 4; i++) begin
        case (ph)
          0: seeds[i] = '1;
          1: seeds[i] = (i == 0) ? 64'h8000_0000_0000_0000 : 64'd1;
          default: seeds[i] = {$urandom, $urandom};
        endcase
      end
      write_reg(lkey_pkg::RegSeed0, seeds[0]);
      write_reg(lkey_pkg::RegSeed1, seeds[1]);
      write_reg(lkey_pkg::RegSeed2, seeds[2]);
      write_reg(lkey_pkg::RegSeed3, seeds[3]);
      // Indexes past the seed registers must leave the seed alone.
      write_reg(3'($urandom_range(4, 7)), {$urandom, $urandom});
      @(posedge clk_i);
      if (ph == 0) begin
        send_slot(9'd0);
        send_slot(9'd511);
      end
      if (ph == 2) begin
        fork
          random_slots(310);
          begin
            repeat (200) @(posedge clk_i);
            long_hold_req = 1'b1;
          end
        join
      end else begin
        random_slots(310);
      end
      drain();
    end

    if (sb.errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
